// ----- rtl/core/ssg_pkg.sv -----
// ----------------------------------------------------------------------------
// ssg_pkg
// Shared types and constants for the scheduled source gate.
// ----------------------------------------------------------------------------
package ssg_pkg;

  // Default render quantum length in sample frames
  localparam int unsigned QUANTUM_FRAMES_DEF = 128;

  // Width of a frame time on the request channel
  localparam int unsigned FRAME_W = 63;

  // Width of the per-quantum frame counts on the result channel
  localparam int unsigned COUNT_W = 8;

  // Request codes
  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_STOP    = 2'd1,
    OP_RESET   = 2'd2,
    OP_QUANTUM = 2'd3
  } opcode_e;

  // One request
  typedef struct packed {
    opcode_e                    opcode;
    logic signed [FRAME_W-1:0]  time_frame;
  } item_t;

  // Input stage contents handed to the evaluation stage
  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

  // One result
  typedef struct packed {
    logic               accepted;
    logic [COUNT_W-1:0] lead_offset;
    logic [COUNT_W-1:0] active_frames;
    logic [COUNT_W-1:0] tail_start;
    logic               ended;
    logic [1:0]         play_state;
  } result_t;

endpackage

// ----- rtl/core/ssg_in_stage.sv -----
// ----------------------------------------------------------------------------
// ssg_in_stage
// Input register: captures one request per cycle and holds it while the
// evaluation stage is blocked by a stalled result.
// ----------------------------------------------------------------------------
module ssg_in_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       opcode_i,
  input  logic signed [ssg_pkg::FRAME_W-1:0] time_frame_i,
  input  logic             adv_i,
  output ssg_pkg::stage_t  stage_o
);
  import ssg_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  logic  take;

  // Stall only while holding a request that cannot move on
  assign in_stall_o = valid_q & ~adv_i;
  assign take       = in_valid_i & ~in_stall_o;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (adv_i || !valid_q) begin
      valid_d = in_valid_i;
    end
    if (take) begin
      item_d.opcode     = opcode_e'(opcode_i);
      item_d.time_frame = time_frame_i;
    end
  end

  // Control bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign stage_o.valid = valid_q;
  assign stage_o.item  = item_q;

endmodule

// ----- rtl/core/ssg_sched.sv -----
// ----------------------------------------------------------------------------
// ssg_sched
// Scheduling state and per-request evaluation. Applies pending start and
// stop times at each quantum, works out the silent lead, sounding frames and
// silent tail, and registers the result.
// ----------------------------------------------------------------------------
module ssg_sched #(
  parameter int unsigned QuantumFrames = ssg_pkg::QUANTUM_FRAMES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  ssg_pkg::item_t    item_i,
  output ssg_pkg::result_t  res_o
);
  import ssg_pkg::*;

  // Frame offsets inside one quantum stay below QuantumFrames
  localparam int unsigned CntW = $clog2(QuantumFrames + 1);
  localparam int unsigned OutW = (CntW > COUNT_W) ? CntW : COUNT_W;
  localparam logic [CntW-1:0] QCnt = CntW'(QuantumFrames);
  localparam logic [OutW-1:0] QOut = OutW'(QuantumFrames);
  localparam logic signed [63:0] QWide = 64'(QuantumFrames);

  typedef enum logic [1:0] {
    MODE_UNSCHED = 2'd0,
    MODE_SCHED   = 2'd1,
    MODE_PLAY    = 2'd2,
    MODE_DONE    = 2'd3
  } mode_e;

  mode_e                     mode_q, mode_d;
  logic signed [FRAME_W-1:0] start_at_q, start_at_d;
  logic signed [FRAME_W-1:0] stop_at_q, stop_at_d;
  logic                      stop_known_q, stop_known_d;
  logic signed [FRAME_W-1:0] pend_start_q, pend_start_d;
  logic                      pend_start_v_q, pend_start_v_d;
  logic signed [FRAME_W-1:0] pend_stop_q, pend_stop_d;
  logic                      pend_stop_v_q, pend_stop_v_d;
  result_t                   res_q, res_d;

  logic signed [63:0] qs, qe, start_w, stop_w;
  logic signed [63:0] off_diff, zs_diff;
  logic [CntW-1:0]    off, zs;
  logic [OutW-1:0]    lead, act, tail;
  logic               acc, ended, in_quantum;
  logic               neg_t;

  // Evaluate one request against the current state
  always_comb begin
    mode_d         = mode_q;
    start_at_d     = start_at_q;
    stop_at_d      = stop_at_q;
    stop_known_d   = stop_known_q;
    pend_start_d   = pend_start_q;
    pend_start_v_d = pend_start_v_q;
    pend_stop_d    = pend_stop_q;
    pend_stop_v_d  = pend_stop_v_q;

    acc   = 1'b1;
    ended = 1'b0;
    lead  = '0;
    act   = '0;
    tail  = QOut;
    neg_t = item_i.time_frame[FRAME_W-1];

    qs = 64'(item_i.time_frame);
    qe = qs + QWide;

    // Quantum sees the freshly applied times
    start_w  = pend_start_v_q ? 64'(pend_start_q) : 64'(start_at_q);
    stop_w   = pend_stop_v_q ? 64'(pend_stop_q) : 64'(stop_at_q);
    off_diff = start_w - qs;
    zs_diff  = stop_w - qs;
    off      = (start_w > qs) ? off_diff[CntW-1:0] : '0;
    zs       = zs_diff[CntW-1:0];
    in_quantum = 1'b0;

    unique case (item_i.opcode)
      OP_START: begin
        if (mode_q == MODE_PLAY || neg_t) begin
          acc = 1'b0;
        end else begin
          pend_start_d   = item_i.time_frame;
          pend_start_v_d = 1'b1;
          stop_known_d   = 1'b0;
          mode_d         = MODE_SCHED;
        end
      end
      OP_STOP: begin
        pend_stop_d   = neg_t ? '0 : item_i.time_frame;
        pend_stop_v_d = 1'b1;
      end
      OP_RESET: begin
        pend_stop_v_d = 1'b0;
        mode_d        = MODE_UNSCHED;
      end
      OP_QUANTUM: begin
        stop_at_d      = FRAME_W'(stop_w);
        start_at_d     = FRAME_W'(start_w);
        stop_known_d   = stop_known_q | pend_stop_v_q;
        pend_start_v_d = 1'b0;
        pend_stop_v_d  = 1'b0;

        // Stop already reached: finish silently
        if (stop_known_d && stop_w <= qs) begin
          ended  = (mode_q != MODE_DONE);
          mode_d = MODE_DONE;
        end

        // Sounding part of the quantum
        if (!(mode_d == MODE_UNSCHED || mode_d == MODE_DONE || start_w >= qe)) begin
          if (mode_d == MODE_SCHED) begin
            mode_d = MODE_PLAY;
          end
          lead = OutW'(off);
          act  = OutW'(QCnt - off);
          in_quantum = stop_known_d && (stop_w >= qs) && (stop_w < qe);
          // Stop inside the quantum: silent tail from the stop frame
          if (in_quantum) begin
            act    = (zs >= off) ? OutW'(zs - off) : '0;
            tail   = OutW'(zs);
            ended  = ended | (mode_d != MODE_DONE);
            mode_d = MODE_DONE;
          end
        end
      end
      default: begin
        acc = 1'b1;
      end
    endcase

    res_d.accepted      = acc;
    res_d.lead_offset   = lead[COUNT_W-1:0];
    res_d.active_frames = act[COUNT_W-1:0];
    res_d.tail_start    = tail[COUNT_W-1:0];
    res_d.ended         = ended;
    res_d.play_state    = mode_d;
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= MODE_UNSCHED;
      start_at_q     <= '0;
      stop_at_q      <= '0;
      stop_known_q   <= 1'b0;
      pend_start_q   <= '0;
      pend_start_v_q <= 1'b0;
      pend_stop_q    <= '0;
      pend_stop_v_q  <= 1'b0;
    end else if (load_i) begin
      mode_q         <= mode_d;
      start_at_q     <= start_at_d;
      stop_at_q      <= stop_at_d;
      stop_known_q   <= stop_known_d;
      pend_start_q   <= pend_start_d;
      pend_start_v_q <= pend_start_v_d;
      pend_stop_q    <= pend_stop_d;
      pend_stop_v_q  <= pend_stop_v_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

  // An ended pulse always reports the finished state
  a_ended_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> (!res_q.ended || (res_q.play_state == 2'(MODE_DONE))))
    else $error("ended pulse without finished state");

  // Only quanta carry sounding frames
  a_idle_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_i && item_i.opcode != OP_QUANTUM) |=> (res_q.active_frames == '0))
    else $error("non-quantum request reported active frames");

  // A quantum consumes every pending time
  a_pend_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_i && item_i.opcode == OP_QUANTUM) |=> (!pend_start_v_q && !pend_stop_v_q))
    else $error("pending time survived a quantum");

  // Start while playing is refused and leaves the mode alone
  a_start_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_i && item_i.opcode == OP_START && mode_q == MODE_PLAY)
      |=> (!res_q.accepted && mode_q == MODE_PLAY))
    else $error("start accepted while playing");

endmodule

// ----- rtl/core/scheduled_source_gate.sv -----
// ----------------------------------------------------------------------------
// scheduled_source_gate
// Playback gate for a scheduled audio source. Requests are start, stop,
// reset and render quantum, with times already given in sample frames.
// Start and stop are held pending and applied at the next quantum; each
// quantum request returns the silent lead, the count of sounding frames,
// the frame where the silent tail starts and a pulse on entry to finished.
// Every request yields exactly one result. The block takes one request per
// clock cycle while the result side does not stall: an accepted request
// sits in the input register while the evaluation logic settles, and the
// result register then captures the result. Each request is evaluated
// combinationally against the state left by the one before it. A stalled
// result holds the result register and a request in the input register,
// so the request side stalls once the input register is full.
// ----------------------------------------------------------------------------
module scheduled_source_gate #(
  parameter int unsigned QuantumFrames = ssg_pkg::QUANTUM_FRAMES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Request channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          opcode_i,
  input  logic signed [ssg_pkg::FRAME_W-1:0]  time_frame_i,
  // Result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                accepted_o,
  output logic [ssg_pkg::COUNT_W-1:0]         lead_offset_o,
  output logic [ssg_pkg::COUNT_W-1:0]         active_frames_o,
  output logic [ssg_pkg::COUNT_W-1:0]         tail_start_o,
  output logic                                ended_o,
  output logic [1:0]                          play_state_o
);
  import ssg_pkg::*;

  stage_t  stage;
  result_t res;
  logic    out_valid_q, out_valid_d;
  logic    out_ready;
  logic    load;

  // Result register can take a new result when empty or being drained
  assign out_ready   = ~out_valid_q | ~out_stall_i;
  assign load        = stage.valid & out_ready;
  assign out_valid_d = out_ready ? stage.valid : 1'b1;

  ssg_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .time_frame_i (time_frame_i),
    .adv_i        (out_ready),
    .stage_o      (stage)
  );

  ssg_sched #(
    .QuantumFrames (QuantumFrames)
  ) u_sched (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (load),
    .item_i (stage.item),
    .res_o  (res)
  );

  // Result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign accepted_o      = res.accepted;
  assign lead_offset_o   = res.lead_offset;
  assign active_frames_o = res.active_frames;
  assign tail_start_o    = res.tail_start;
  assign ended_o         = res.ended;
  assign play_state_o    = res.play_state;

endmodule

// ----- dv/tb_scheduled_source_gate.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_scheduled_source_gate
// Self-checking bench for the scheduled source gate. A short table of
// requests covers the frame extremes, every request code and the playback
// corner cases. Random schedules follow: start and stop frames placed
// around a running quantum cursor, with some noise. Each result is checked
// against its table entry or a cycle-free model of the playback state.
// ----------------------------------------------------------------------------
module tb_scheduled_source_gate;
  import ssg_pkg::*;

  // Playback states as reported on play_state_o
  typedef enum logic [1:0] {
    PS_UNSCHED  = 2'd0,
    PS_SCHED    = 2'd1,
    PS_PLAYING  = 2'd2,
    PS_FINISHED = 2'd3
  } play_state_e;

  // One row of the directed table
  typedef struct {
    opcode_e                   op;
    logic signed [FRAME_W-1:0] tf;
    bit                        typed;
    result_t                   res;
  } dir_row_t;

  localparam longint QUANTUM = QUANTUM_FRAMES_DEF;
  localparam logic [COUNT_W-1:0] TAIL_NONE = COUNT_W'(QUANTUM_FRAMES_DEF);
  localparam logic signed [FRAME_W-1:0] FRAME_MAX = {1'b0, {(FRAME_W-1){1'b1}}};
  localparam logic signed [FRAME_W-1:0] FRAME_MIN = {1'b1, {(FRAME_W-1){1'b0}}};
  localparam int RANDOM_REQS = 1100;
  localparam int QUIET_REQS  = 100;
  localparam int MAX_PRINTS  = 40;

  // DUT ports
  logic                      clk_i        = 1'b0;
  logic                      rst_ni       = 1'b0;
  logic                      in_valid_i   = 1'b0;
  logic                      in_stall_o;
  logic [1:0]                opcode_i     = OP_RESET;
  logic signed [FRAME_W-1:0] time_frame_i = '0;
  logic                      out_valid_o;
  logic                      out_stall_i  = 1'b0;
  logic                      accepted_o;
  logic [COUNT_W-1:0]        lead_offset_o;
  logic [COUNT_W-1:0]        active_frames_o;
  logic [COUNT_W-1:0]        tail_start_o;
  logic                      ended_o;
  logic [1:0]                play_state_o;

  // Model state of the gate
  play_state_e gate_mode      = PS_UNSCHED;
  longint      start_frame    = 0;
  longint      stop_frame     = 0;
  bit          stop_set       = 1'b0;
  longint      pend_start     = 0;
  bit          pend_start_set = 1'b0;
  longint      pend_stop      = 0;
  bit          pend_stop_set  = 1'b0;

  // Bench bookkeeping
  result_t  expected_results[$];
  dir_row_t dir_rows[$];
  int       err_count    = 0;
  int       results_seen = 0;
  int       ended_seen   = 0;
  int       op_count[4]  = '{0, 0, 0, 0};
  bit       quiet        = 1'b0;
  bit       in_calm      = 1'b0;
  bit       out_calm     = 1'b0;
  int       stall_left   = 0;

  scheduled_source_gate u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .opcode_i        (opcode_i),
    .time_frame_i    (time_frame_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .accepted_o      (accepted_o),
    .lead_offset_o   (lead_offset_o),
    .active_frames_o (active_frames_o),
    .tail_start_o    (tail_start_o),
    .ended_o         (ended_o),
    .play_state_o    (play_state_o)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Model of one request: updates playback state, returns the result
  function automatic result_t gate_predict(opcode_e op, longint t);
    result_t r;
    longint  qe, off, n, zs, fz;
    r            = '0;
    r.accepted   = 1'b1;
    r.tail_start = TAIL_NONE;
    case (op)
      OP_START: begin
        // refused while playing or for a negative frame
        if (gate_mode == PS_PLAYING || t < 0) begin
          r.accepted = 1'b0;
        end else begin
          pend_start     = t;
          pend_start_set = 1'b1;
          stop_set       = 1'b0;
          gate_mode      = PS_SCHED;
        end
      end
      OP_STOP: begin
        pend_stop     = (t < 0) ? 0 : t;
        pend_stop_set = 1'b1;
      end
      OP_RESET: begin
        pend_stop_set = 1'b0;
        gate_mode     = PS_UNSCHED;
      end
      default: begin
        qe = t + QUANTUM;
        // pending times take effect at the quantum
        if (pend_stop_set) begin
          stop_frame    = pend_stop;
          stop_set      = 1'b1;
          pend_stop_set = 1'b0;
        end
        if (pend_start_set) begin
          start_frame    = pend_start;
          pend_start_set = 1'b0;
        end
        // stop already passed
        if (stop_set && stop_frame <= t) begin
          r.ended   = (gate_mode != PS_FINISHED);
          gate_mode = PS_FINISHED;
        end
        if ((gate_mode == PS_SCHED || gate_mode == PS_PLAYING) && start_frame < qe) begin
          if (gate_mode == PS_SCHED) gate_mode = PS_PLAYING;
          off = (start_frame > t) ? start_frame - t : 0;
          if (off > QUANTUM) off = QUANTUM;
          n = QUANTUM - off;
          r.lead_offset   = off[COUNT_W-1:0];
          r.active_frames = n[COUNT_W-1:0];
          // stop lands inside this quantum
          if (n != 0 && stop_set && stop_frame >= t && stop_frame < qe) begin
            zs = stop_frame - t;
            fz = QUANTUM - zs;
            n  = (fz > n) ? 0 : n - fz;
            r.active_frames = n[COUNT_W-1:0];
            r.tail_start    = zs[COUNT_W-1:0];
            r.ended         = r.ended | (gate_mode != PS_FINISHED);
            gate_mode       = PS_FINISHED;
          end
        end
      end
    endcase
    r.play_state = gate_mode;
    return r;
  endfunction

  // Result of a non-quantum request or a silent quantum
  function automatic result_t silent_res(bit acc, play_state_e st);
    result_t r;
    r            = '0;
    r.accepted   = acc;
    r.tail_start = TAIL_NONE;
    r.play_state = st;
    return r;
  endfunction

  function automatic void add_row(opcode_e op, logic signed [FRAME_W-1:0] tf,
                                  bit typed = 1'b0, result_t res = '0);
    dir_row_t row;
    row.op    = op;
    row.tf    = tf;
    row.typed = typed;
    row.res   = res;
    dir_rows.push_back(row);
  endfunction

  // Sender idle burst length, zero most of the time
  function automatic int next_gap();
    if (!quiet && !in_calm && $urandom_range(0, 7) == 0) return $urandom_range(1, 17);
    return 0;
  endfunction

  task automatic report_mismatch(string msg);
    if (err_count < MAX_PRINTS) $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  task automatic check_result(result_t got, result_t want);
    if (got.accepted !== want.accepted)
      report_mismatch($sformatf("result %0d accepted got %0d want %0d",
                                results_seen, got.accepted, want.accepted));
    if (got.lead_offset !== want.lead_offset)
      report_mismatch($sformatf("result %0d lead_offset got %0d want %0d",
                                results_seen, got.lead_offset, want.lead_offset));
    if (got.active_frames !== want.active_frames)
      report_mismatch($sformatf("result %0d active_frames got %0d want %0d",
                                results_seen, got.active_frames, want.active_frames));
    if (got.tail_start !== want.tail_start)
      report_mismatch($sformatf("result %0d tail_start got %0d want %0d",
                                results_seen, got.tail_start, want.tail_start));
    if (got.ended !== want.ended)
      report_mismatch($sformatf("result %0d ended got %0d want %0d",
                                results_seen, got.ended, want.ended));
    if (got.play_state !== want.play_state)
      report_mismatch($sformatf("result %0d play_state got %0d want %0d",
                                results_seen, got.play_state, want.play_state));
  endtask

  // Drive one request and record its expected result once accepted
  task automatic send_request(opcode_e op, logic signed [FRAME_W-1:0] tf, int gap,
                              bit typed, result_t typed_res);
    result_t predicted;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    time_frame_i <= tf;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = gate_predict(op, longint'(tf));
    expected_results.push_back(typed ? typed_res : predicted);
    op_count[op]++;
  endtask

  // Hold off the sender until every outstanding result is back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
  endtask

  // Receiver stall bursts, with calm stretches
  always @(posedge clk_i) begin
    if ($urandom_range(0, 199) == 0) out_calm = !out_calm;
    if (stall_left > 0 && !quiet) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (!quiet && !out_calm && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 16);
      out_stall_i <= 1'b1;
    end else begin
      stall_left = 0;
      out_stall_i <= 1'b0;
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {accepted_o, lead_offset_o, active_frames_o, tail_start_o, ended_o,
             play_state_o};
      results_seen++;
      if (got.ended) ended_seen++;
      if (expected_results.size() == 0)
        report_mismatch($sformatf("result %0d arrived with none expected", results_seen));
      else
        check_result(got, expected_results.pop_front());
    end
  end

  // Stimulus
  initial begin
    logic signed [FRAME_W-1:0] q_frame;
    logic signed [FRAME_W-1:0] tf;
    opcode_e                   op;
    int                        pick;
    longint                    off;

    // idle source, quanta at zero and at the largest frame
    add_row(OP_QUANTUM, '0, 1'b1, silent_res(1'b1, PS_UNSCHED));
    add_row(OP_QUANTUM, FRAME_MAX, 1'b1, silent_res(1'b1, PS_UNSCHED));
    // negative stop clamps and is accepted
    add_row(OP_STOP, -63'sd5, 1'b1, silent_res(1'b1, PS_UNSCHED));
    // negative starts are refused
    add_row(OP_START, -63'sd1, 1'b1, silent_res(1'b0, PS_UNSCHED));
    add_row(OP_START, FRAME_MIN, 1'b1, silent_res(1'b0, PS_UNSCHED));
    // reset drops the pending stop
    add_row(OP_RESET, '0, 1'b1, silent_res(1'b1, PS_UNSCHED));
    add_row(OP_START, 63'sd200, 1'b1, silent_res(1'b1, PS_SCHED));
    // start beyond the quantum stays scheduled
    add_row(OP_QUANTUM, '0, 1'b1, silent_res(1'b1, PS_SCHED));
    // start inside the quantum: silent lead then playing
    add_row(OP_QUANTUM, 63'sd128);
    // start while playing is refused
    add_row(OP_START, '0, 1'b1, silent_res(1'b0, PS_PLAYING));
    add_row(OP_STOP, 63'sd300, 1'b1, silent_res(1'b1, PS_PLAYING));
    // stop inside the quantum finishes the source
    add_row(OP_QUANTUM, 63'sd256);
    // already finished: no second ended pulse
    add_row(OP_QUANTUM, 63'sd384);
    add_row(OP_START, FRAME_MAX, 1'b1, silent_res(1'b1, PS_SCHED));
    add_row(OP_QUANTUM, FRAME_MIN);
    add_row(OP_QUANTUM, FRAME_MAX - 63'sd127);
    add_row(OP_RESET, FRAME_MAX, 1'b1, silent_res(1'b1, PS_UNSCHED));
    // stop clamped to zero has passed by the first quantum
    add_row(OP_START, '0);
    add_row(OP_STOP, -63'sd100);
    add_row(OP_QUANTUM, '0);
    // stop before the start within one quantum: nothing sounds
    add_row(OP_START, 63'sd100);
    add_row(OP_STOP, 63'sd50);
    add_row(OP_QUANTUM, '0);
    // reset keeps a pending start but leaves the source unscheduled
    add_row(OP_START, 63'sd5);
    add_row(OP_RESET, '0);
    add_row(OP_QUANTUM, '0, 1'b1, silent_res(1'b1, PS_UNSCHED));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      send_request(dir_rows[i].op, dir_rows[i].tf, next_gap(), dir_rows[i].typed,
                   dir_rows[i].res);
    drain_results();

    // Random schedules around a moving quantum cursor
    q_frame = '0;
    for (int k = 0; k < RANDOM_REQS; k++) begin
      if (k == RANDOM_REQS - QUIET_REQS) quiet = 1'b1;
      if (k % 64 == 0) in_calm = ($urandom_range(0, 3) == 0);
      if (k == 400 || k == 800) drain_results();
      // occasionally move the cursor, extremes included
      if ($urandom_range(0, 39) == 0) begin
        case ($urandom_range(0, 3))
          0:       q_frame = FRAME_W'($urandom_range(0, 1000));
          1:       q_frame = FRAME_W'({$urandom, $urandom});
          2:       q_frame = FRAME_MAX - FRAME_W'($urandom_range(0, 2000));
          default: q_frame = FRAME_MIN + FRAME_W'($urandom_range(0, 2000));
        endcase
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        op = OP_QUANTUM;
        tf = q_frame;
        if ($urandom_range(0, 4) == 0)
          q_frame = q_frame + FRAME_W'($urandom_range(1, 300));
        else
          q_frame = q_frame + FRAME_W'(QUANTUM);
      end else if (pick < 78) begin
        op  = (pick < 62) ? OP_START : OP_STOP;
        off = longint'($urandom_range(0, 700)) - 150;
        tf  = FRAME_W'(longint'(q_frame) + off);
      end else if (pick < 84) begin
        op = OP_RESET;
        tf = FRAME_W'({$urandom, $urandom});
      end else begin
        op = opcode_e'($urandom_range(0, 3));
        tf = FRAME_W'({$urandom, $urandom});
      end
      send_request(op, tf, next_gap(), 1'b0, '0);
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived",
                                expected_results.size()));

    $display("Checked %0d results: %0d start, %0d stop, %0d reset, %0d quantum requests",
             results_seen, op_count[OP_START], op_count[OP_STOP], op_count[OP_RESET],
             op_count[OP_QUANTUM]);
    $display("Ended pulses seen: %0d, frames spanning both signed extremes", ended_seen);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
